[sv/cwev_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package cwev_pkg;

    localparam int MAX_WINDOW = 1024;
    localparam int MAX_ROWS   = 32;

    localparam int SMP_W    = 16;
    localparam int CL_W     = 11;
    localparam int RL_W     = 12;
    localparam int MR_W     = 6;
    localparam int POS_W    = 11;
    localparam int MAG_W    = 16;
    localparam int SQ_W     = 2 * MAG_W;
    localparam int ENERGY_W = 41;
    localparam int FRAC_W   = 16;
    localparam int CONF_W   = FRAC_W + 1;
    localparam int DIVD_W   = MR_W + FRAC_W;
    localparam int REM_W    = MR_W + 1;
    localparam int CNT_W    = $clog2(DIVD_W);

    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 12;

    localparam int OUT_FIELDS_W = 1 + CL_W + MR_W + MR_W + CONF_W;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = FIFO_AW + 1;

    localparam logic [SMP_W-1:0]  MIDSCALE = SMP_W'(32768);
    localparam logic [CONF_W-1:0] CONF_ONE = CONF_W'(1) << FRAC_W;

    localparam logic [CFG_IDX_W-1:0] REG_CHIRP_LEN = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_DEAD_LEN  = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_ROW_LEN   = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_MAX_ROWS  = CFG_IDX_W'(3);

    localparam logic [CL_W-1:0] CHIRP_LEN_RST = CL_W'(512);
    localparam logic [CL_W-1:0] DEAD_LEN_RST  = CL_W'(512);
    localparam logic [RL_W-1:0] ROW_LEN_RST   = RL_W'(1024);
    localparam logic [MR_W-1:0] MAX_ROWS_RST  = MR_W'(32);

    typedef struct packed {
        logic [MR_W-1:0] aligned;
        logic [MR_W-1:0] checked;
        logic [CL_W-1:0] chirp_len;
    } cwev_rec_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_DIV,
        BK_OUT
    } cwev_back_state_t;

endpackage

`default_nettype wire

[sv/chirp_window_energy_vote_top.sv]
`timescale 1ns / 1ps
`default_nettype none

// Chirp window energy vote. Takes one offset-binary ADC sample per cycle on
// the s_ stream; s_tready drops only while the four-entry result queue, plus
// frame ends still in flight in the three front pipeline stages (classify,
// square, then accumulate and vote), would fill it. A frame end passes the
// classify and square registers and is written into the queue from the
// accumulate stage. The back end then takes one queued frame at a time: it
// loads the record, runs a restoring divider for the confidence at one
// quotient bit per cycle (skipped when no row voted), and holds the result on
// the m_ stream until taken; only then does it load the next frame.
// Configuration writes are taken in any cycle, always with cfg_ready high,
// and belong only to idle periods; there is no clearing pass after reset.
module chirp_window_energy_vote_top (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    // [15:0] sample
    input  wire logic [cwev_pkg::SMP_W-1:0]          s_tdata,
    input  wire logic                                s_tlast,
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [cwev_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [cwev_pkg::CFG_DATA_W-1:0]     cfg_data,
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    // [0] inverted, [11:1] sample_offset, [17:12] agree_votes,
    // [23:18] rows_checked, [40:24] confidence_q16, [47:41] zero
    output logic [cwev_pkg::OUT_TDATA_W-1:0]         m_tdata
);
    import cwev_pkg::*;

    logic               rec_push;
    cwev_rec_t          rec_in;
    cwev_rec_t          rec_out;
    logic               rec_pop;
    logic               rec_avail;
    logic [FIFO_CW-1:0] rec_count;

    cwev_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_sample    (s_tdata),
        .s_frame_end (s_tlast),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .fifo_count  (rec_count),
        .rec_push    (rec_push),
        .rec         (rec_in)
    );

    cwev_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (rec_push),
        .push_data (rec_in),
        .pop       (rec_pop),
        .pop_data  (rec_out),
        .not_empty (rec_avail),
        .count     (rec_count)
    );

    cwev_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .fifo_valid (rec_avail),
        .fifo_pop   (rec_pop),
        .rec        (rec_out),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

endmodule

`default_nettype wire

[sv/cwev_front.sv]
`timescale 1ns / 1ps
`default_nettype none

module cwev_front (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [cwev_pkg::SMP_W-1:0]      s_sample,
    input  wire logic                            s_frame_end,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [cwev_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [cwev_pkg::CFG_DATA_W-1:0] cfg_data,
    input  wire logic [cwev_pkg::FIFO_CW-1:0]    fifo_count,
    output logic                                 rec_push,
    output cwev_pkg::cwev_rec_t                  rec
);
    import cwev_pkg::*;

    logic [CL_W-1:0] chirp_len_reg;
    logic [CL_W-1:0] dead_len_reg;
    logic [RL_W-1:0] row_len_reg;
    logic [MR_W-1:0] max_rows_reg;

    logic [CL_W-1:0] cl;
    logic [CL_W-1:0] dl;
    logic [RL_W-1:0] rl;
    logic [MR_W-1:0] mr;
    logic [RL_W-1:0] sum_cd;
    logic [RL_W-1:0] eff_raw;
    logic [RL_W-1:0] eff;

    logic [POS_W-1:0] pos_reg;
    logic [POS_W-1:0] pos_next;
    logic [RL_W-1:0]  pos_ext;
    logic             in_chirp;
    logic             in_dead;
    logic             row_end;
    logic [MAG_W-1:0] mag;
    logic             accept;

    logic             a_valid_reg;
    logic             a_chirp_reg;
    logic             a_dead_reg;
    logic             a_end_reg;
    logic             a_fe_reg;
    logic [MAG_W-1:0] a_mag_reg;

    logic             b_valid_reg;
    logic             b_chirp_reg;
    logic             b_dead_reg;
    logic             b_end_reg;
    logic             b_fe_reg;
    logic [SQ_W-1:0]  b_sq_reg;

    logic [ENERGY_W-1:0] chirp_acc_reg;
    logic [ENERGY_W-1:0] dead_acc_reg;
    logic [ENERGY_W-1:0] chirp_acc_next;
    logic [ENERGY_W-1:0] dead_acc_next;
    logic [ENERGY_W-1:0] snap_chirp_reg;
    logic [ENERGY_W-1:0] snap_dead_reg;
    logic                c_valid_reg;
    logic                c_end_reg;
    logic                c_fe_reg;

    logic [MR_W-1:0] aligned_reg;
    logic [MR_W-1:0] rows_reg;
    logic [MR_W-1:0] aligned_next;
    logic [MR_W-1:0] rows_next;
    logic            vote_take;
    logic            vote_aligned;

    logic [1:0]         inflight;
    logic [FIFO_CW:0]   credit_sum;

    // configuration
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            chirp_len_reg <= CHIRP_LEN_RST;
            dead_len_reg  <= DEAD_LEN_RST;
            row_len_reg   <= ROW_LEN_RST;
            max_rows_reg  <= MAX_ROWS_RST;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_CHIRP_LEN: chirp_len_reg <= cfg_data[CL_W-1:0];
                REG_DEAD_LEN:  dead_len_reg  <= cfg_data[CL_W-1:0];
                REG_ROW_LEN:   row_len_reg   <= cfg_data[RL_W-1:0];
                REG_MAX_ROWS:  max_rows_reg  <= cfg_data[MR_W-1:0];
                default: ;
            endcase
        end
    end

    assign cl = (chirp_len_reg > CL_W'(MAX_WINDOW)) ? CL_W'(MAX_WINDOW) : chirp_len_reg;
    assign dl = (dead_len_reg > CL_W'(MAX_WINDOW)) ? CL_W'(MAX_WINDOW) : dead_len_reg;
    assign rl = (row_len_reg > RL_W'(2 * MAX_WINDOW)) ? RL_W'(2 * MAX_WINDOW) : row_len_reg;
    assign mr = (max_rows_reg > MR_W'(MAX_ROWS)) ? MR_W'(MAX_ROWS) : max_rows_reg;

    assign sum_cd  = RL_W'(cl) + RL_W'(dl);
    assign eff_raw = (rl > sum_cd) ? rl : sum_cd;
    assign eff     = (eff_raw == '0) ? RL_W'(1) : eff_raw;

    // classify the accepted beat
    assign inflight = 2'(a_valid_reg & a_fe_reg) + 2'(b_valid_reg & b_fe_reg)
                    + 2'(c_valid_reg & c_fe_reg);
    assign credit_sum = (FIFO_CW + 1)'(fifo_count) + (FIFO_CW + 1)'(inflight);
    assign s_tready   = credit_sum < (FIFO_CW + 1)'(FIFO_DEPTH);
    assign accept     = s_tvalid && s_tready;

    assign pos_ext  = RL_W'(pos_reg);
    assign in_chirp = pos_ext < RL_W'(cl);
    assign in_dead  = !in_chirp && (pos_ext < sum_cd);
    assign row_end  = (pos_ext + RL_W'(1)) >= eff;
    assign mag      = (s_sample >= MIDSCALE) ? (s_sample - MIDSCALE) : (MIDSCALE - s_sample);

    always_comb begin
        pos_next = pos_reg;
        if (accept) begin
            if (row_end || s_frame_end) begin
                pos_next = '0;
            end else begin
                pos_next = pos_reg + POS_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg     <= '0;
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end else begin
            pos_reg     <= pos_next;
            a_valid_reg <= accept;
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        a_chirp_reg <= in_chirp;
        a_dead_reg  <= in_dead;
        a_end_reg   <= row_end;
        a_fe_reg    <= s_frame_end;
        a_mag_reg   <= mag;
        b_chirp_reg <= a_chirp_reg;
        b_dead_reg  <= a_dead_reg;
        b_end_reg   <= a_end_reg;
        b_fe_reg    <= a_fe_reg;
        b_sq_reg    <= a_mag_reg * a_mag_reg;
    end

    // accumulate window energies
    assign chirp_acc_next = chirp_acc_reg + (b_chirp_reg ? ENERGY_W'(b_sq_reg) : '0);
    assign dead_acc_next  = dead_acc_reg + (b_dead_reg ? ENERGY_W'(b_sq_reg) : '0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            chirp_acc_reg <= '0;
            dead_acc_reg  <= '0;
            c_valid_reg   <= 1'b0;
        end else begin
            c_valid_reg <= b_valid_reg;
            if (b_valid_reg) begin
                if (b_end_reg || b_fe_reg) begin
                    chirp_acc_reg <= '0;
                    dead_acc_reg  <= '0;
                end else begin
                    chirp_acc_reg <= chirp_acc_next;
                    dead_acc_reg  <= dead_acc_next;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        c_end_reg      <= b_end_reg;
        c_fe_reg       <= b_fe_reg;
        snap_chirp_reg <= chirp_acc_next;
        snap_dead_reg  <= dead_acc_next;
    end

    // vote and close the frame
    assign vote_take    = c_valid_reg && c_end_reg && (rows_reg < mr);
    assign vote_aligned = vote_take && (snap_chirp_reg >= snap_dead_reg);
    assign aligned_next = aligned_reg + MR_W'(vote_aligned);
    assign rows_next    = rows_reg + MR_W'(vote_take);

    assign rec_push      = c_valid_reg && c_fe_reg;
    assign rec.aligned   = aligned_next;
    assign rec.checked   = rows_next;
    assign rec.chirp_len = cl;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            aligned_reg <= '0;
            rows_reg    <= '0;
        end else if (rec_push) begin
            aligned_reg <= '0;
            rows_reg    <= '0;
        end else begin
            aligned_reg <= aligned_next;
            rows_reg    <= rows_next;
        end
    end

    a_votes_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        (aligned_reg <= rows_reg) && (rows_reg <= MR_W'(MAX_ROWS)))
        else $error("aligned votes exceed rows checked");

endmodule

`default_nettype wire

[sv/cwev_fifo.sv]
`timescale 1ns / 1ps
`default_nettype none

module cwev_fifo (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         push,
    input  cwev_pkg::cwev_rec_t               push_data,
    input  wire logic                         pop,
    output cwev_pkg::cwev_rec_t               pop_data,
    output logic                              not_empty,
    output logic [cwev_pkg::FIFO_CW-1:0]      count
);
    import cwev_pkg::*;

    cwev_rec_t            mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   wr_ptr_reg;
    logic [FIFO_AW-1:0]   rd_ptr_reg;
    logic [FIFO_CW-1:0]   count_reg;

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + FIFO_AW'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + FIFO_AW'(1);
            end
            count_reg <= count_reg + FIFO_CW'(push) - FIFO_CW'(pop);
        end
    end

    assign pop_data  = mem[rd_ptr_reg];
    assign not_empty = count_reg != '0;
    assign count     = count_reg;

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> (count_reg < FIFO_CW'(FIFO_DEPTH)) || pop)
        else $error("result queue overflow");

    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> count_reg != '0)
        else $error("result queue underflow");

endmodule

`default_nettype wire

[sv/cwev_back.sv]
`timescale 1ns / 1ps
`default_nettype none

module cwev_back (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              fifo_valid,
    output logic                                   fifo_pop,
    input  cwev_pkg::cwev_rec_t                    rec,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic [cwev_pkg::OUT_TDATA_W-1:0]       m_tdata
);
    import cwev_pkg::*;

    cwev_back_state_t state_reg;
    cwev_back_state_t state_next;

    logic load;
    logic div_step;

    logic [MR_W-1:0]   checked_reg;
    logic [MR_W-1:0]   agree_reg;
    logic              inv_reg;
    logic [CL_W-1:0]   offs_reg;
    logic [DIVD_W-1:0] divd_reg;
    logic [REM_W-1:0]  rem_reg;
    logic [DIVD_W-1:0] quo_reg;
    logic [CNT_W-1:0]  cnt_reg;

    logic              rec_inv;
    logic [MR_W-1:0]   rec_agree;
    logic [REM_W-1:0]  rem_sh;
    logic              rem_ge;
    logic [REM_W-1:0]  rem_next;
    logic [CONF_W-1:0] conf;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE: begin
                if (fifo_valid) begin
                    state_next = (rec.checked == '0) ? BK_OUT : BK_DIV;
                end
            end
            BK_DIV: begin
                if (cnt_reg == CNT_W'(DIVD_W - 1)) begin
                    state_next = BK_OUT;
                end
            end
            BK_OUT: begin
                if (m_tready) begin
                    state_next = BK_IDLE;
                end
            end
            default: state_next = BK_IDLE;
        endcase
    end

    always_comb begin
        load     = 1'b0;
        div_step = 1'b0;
        fifo_pop = 1'b0;
        m_tvalid = 1'b0;
        case (state_reg)
            BK_IDLE: begin
                load     = fifo_valid;
                fifo_pop = fifo_valid;
            end
            BK_DIV:  div_step = 1'b1;
            BK_OUT:  m_tvalid = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= BK_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // majority decision
    assign rec_inv   = {rec.aligned, 1'b0} < REM_W'(rec.checked);
    assign rec_agree = rec_inv ? (rec.checked - rec.aligned) : rec.aligned;

    // restoring division, one quotient bit per cycle
    assign rem_sh   = {rem_reg[REM_W-2:0], divd_reg[DIVD_W-1]};
    assign rem_ge   = rem_sh >= REM_W'(checked_reg);
    assign rem_next = rem_ge ? (rem_sh - REM_W'(checked_reg)) : rem_sh;

    always_ff @(posedge aclk) begin
        if (load) begin
            checked_reg <= rec.checked;
            agree_reg   <= rec_agree;
            inv_reg     <= rec_inv;
            offs_reg    <= rec_inv ? rec.chirp_len : '0;
            divd_reg    <= {rec_agree, FRAC_W'(0)};
            rem_reg     <= '0;
            quo_reg     <= '0;
            cnt_reg     <= '0;
        end else if (div_step) begin
            divd_reg <= divd_reg << 1;
            rem_reg  <= rem_next;
            quo_reg  <= {quo_reg[DIVD_W-2:0], rem_ge};
            cnt_reg  <= cnt_reg + CNT_W'(1);
        end
    end

    assign conf    = (checked_reg == '0) ? CONF_ONE : quo_reg[CONF_W-1:0];
    assign m_tdata = {{(OUT_TDATA_W - OUT_FIELDS_W){1'b0}},
                      conf, checked_reg, agree_reg, offs_reg, inv_reg};

    a_result_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == BK_OUT) |-> (conf <= CONF_ONE) && (agree_reg <= checked_reg))
        else $error("result out of range");

endmodule

`default_nettype wire

[tb/sv/chirp_window_energy_vote_top_test.sv]
`timescale 1ns / 1ps

module chirp_window_energy_vote_top_test;

    import cwev_pkg::*;

    localparam int IDLE_LIMIT = 5000;
    localparam int SETTLE_CYC = 40;
    localparam int ITEM_GOAL  = 1600;

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LO = CFG_IDX_W'(4);
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_HI = CFG_IDX_W'(255);

    typedef enum int {
        LOUD_CHIRP,
        LOUD_DEAD,
        ALL_MIDSCALE,
        NOISE
    } row_shape_t;

    typedef struct {
        logic              inverted;
        logic [CL_W-1:0]   offset;
        logic [MR_W-1:0]   agree;
        logic [MR_W-1:0]   checked;
        logic [CONF_W-1:0] conf;
    } vote_t;

    class vote_tally;
        logic [CL_W-1:0]     chirp_len_r;
        logic [CL_W-1:0]     dead_len_r;
        logic [RL_W-1:0]     row_len_r;
        logic [MR_W-1:0]     max_rows_r;
        int unsigned         row_pos;
        logic [ENERGY_W-1:0] chirp_e;
        logic [ENERGY_W-1:0] dead_e;
        int unsigned         aligned;
        int unsigned         voted;
        vote_t               pending_votes[$];
        int unsigned         mismatches;
        int unsigned         samples_seen;
        int unsigned         results_seen;

        function new();
            chirp_len_r  = CHIRP_LEN_RST;
            dead_len_r   = DEAD_LEN_RST;
            row_len_r    = ROW_LEN_RST;
            max_rows_r   = MAX_ROWS_RST;
            mismatches   = 0;
            samples_seen = 0;
            results_seen = 0;
            clear_frame();
        endfunction

        function void clear_frame();
            row_pos = 0;
            chirp_e = '0;
            dead_e  = '0;
            aligned = 0;
            voted   = 0;
        endfunction

        function int unsigned clip(int unsigned v, int unsigned hi);
            return v > hi ? hi : v;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_CHIRP_LEN: chirp_len_r = data[CL_W-1:0];
                REG_DEAD_LEN:  dead_len_r  = data[CL_W-1:0];
                REG_ROW_LEN:   row_len_r   = data[RL_W-1:0];
                REG_MAX_ROWS:  max_rows_r  = data[MR_W-1:0];
                default: ;
            endcase
        endfunction

        function void note_sample(logic [SMP_W-1:0] smp, logic last);
            int unsigned cl;
            int unsigned dl;
            int unsigned rl;
            int unsigned mr;
            int unsigned span;
            int unsigned mag;
            int unsigned agree;
            vote_t       want;
            cl = clip(chirp_len_r, MAX_WINDOW);
            dl = clip(dead_len_r, MAX_WINDOW);
            rl = clip(row_len_r, 2 * MAX_WINDOW);
            mr = clip(max_rows_r, MAX_ROWS);
            span = rl > cl + dl ? rl : cl + dl;
            if (span == 0)
                span = 1;
            samples_seen++;
            mag = smp >= MIDSCALE ? smp - MIDSCALE : MIDSCALE - smp;
            if (row_pos < cl)
                chirp_e += ENERGY_W'(mag * mag);
            else if (row_pos < cl + dl)
                dead_e += ENERGY_W'(mag * mag);
            if (row_pos + 1 >= span) begin
                if (voted < mr) begin
                    if (chirp_e >= dead_e)
                        aligned++;
                    voted++;
                end
                row_pos = 0;
                chirp_e = '0;
                dead_e  = '0;
            end else begin
                row_pos++;
            end
            if (!last)
                return;
            if (voted == 0) begin
                want.inverted = 1'b0;
                want.offset   = '0;
                agree         = 0;
                want.conf     = CONF_ONE;
            end else begin
                if (2 * aligned >= voted) begin
                    want.inverted = 1'b0;
                    want.offset   = '0;
                    agree         = aligned;
                end else begin
                    want.inverted = 1'b1;
                    want.offset   = CL_W'(cl);
                    agree         = voted - aligned;
                end
                want.conf = CONF_W'((longint'(agree) << FRAC_W) / voted);
            end
            want.agree   = MR_W'(agree);
            want.checked = MR_W'(voted);
            pending_votes.push_back(want);
            clear_frame();
        endfunction

        function void compare_field(string field, int unsigned want, int unsigned got);
            if (want != got) begin
                $error("%s: expected %0d, got %0d", field, want, got);
                mismatches++;
            end
        endfunction

        function void check_vote(logic [OUT_TDATA_W-1:0] beat);
            vote_t want;
            results_seen++;
            if (pending_votes.size() == 0) begin
                $error("result beat with no frame end awaiting it");
                mismatches++;
                return;
            end
            want = pending_votes.pop_front();
            compare_field("inverted", want.inverted, beat[0]);
            compare_field("sample_offset", want.offset, beat[11:1]);
            compare_field("agree_votes", want.agree, beat[17:12]);
            compare_field("rows_checked", want.checked, beat[23:18]);
            compare_field("confidence_q16", want.conf, beat[40:24]);
        endfunction
    endclass

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [SMP_W-1:0]       s_tdata   = '0;
    logic                   s_tlast   = 1'b0;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;

    vote_tally   tally = new();
    int unsigned idle_pct  = 0;
    int unsigned stall_pct = 0;
    int unsigned idle_run  = 0;
    int unsigned phase_no = 0;

    chirp_window_energy_vote_top DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always #5 aclk = ~aclk;

    always @(negedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= stall_pct);
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready)
                tally.note_sample(s_tdata, s_tlast);
            if (m_tvalid && m_tready)
                tally.check_vote(m_tdata);
            if (cfg_valid && cfg_ready)
                tally.write_reg(cfg_index, cfg_data);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
                idle_run = 0;
            end else begin
                idle_run++;
                if (idle_run >= IDLE_LIMIT) begin
                    $display("timeout after %0d cycles without a beat", idle_run);
                    $display("status: fail");
                    $finish;
                end
            end
        end
    end

    task automatic send_sample(input logic [SMP_W-1:0] smp, input logic last);
        while ($urandom_range(0, 99) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= smp;
        s_tlast  <= last;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
        while (!cfg_ready)
            @(posedge aclk);
        @(negedge aclk);
        cfg_valid <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        while (tally.pending_votes.size() != 0)
            @(negedge aclk);
        repeat (SETTLE_CYC) @(negedge aclk);
    endtask

    task automatic configure(input int unsigned cl, input int unsigned dl,
                             input int unsigned rl, input int unsigned mr);
        write_reg(REG_CHIRP_LEN, CFG_DATA_W'(cl));
        write_reg(REG_DEAD_LEN, CFG_DATA_W'(dl));
        write_reg(REG_ROW_LEN, CFG_DATA_W'(rl));
        write_reg(REG_MAX_ROWS, CFG_DATA_W'(mr));
    endtask

    function automatic logic [SMP_W-1:0] shaped_sample(int unsigned pos, int unsigned cl,
                                                       row_shape_t shape);
        logic [SMP_W-1:0] wild;
        logic [SMP_W-1:0] calm;
        wild = SMP_W'($urandom_range(0, 65535));
        calm = MIDSCALE + SMP_W'($urandom_range(0, 63)) - SMP_W'(32);
        case (shape)
            LOUD_CHIRP:   return pos < cl ? wild : calm;
            LOUD_DEAD:    return pos < cl ? calm : wild;
            ALL_MIDSCALE: return MIDSCALE;
            default:      return wild;
        endcase
    endfunction

    task automatic send_stream(input int unsigned count, input int unsigned span,
                               input int unsigned cl, input bit close, input bit stray);
        int unsigned pos;
        row_shape_t  shape;
        logic        last;
        shape = NOISE;
        for (int unsigned i = 0; i < count; i++) begin
            pos = i % span;
            if (pos == 0)
                shape = row_shape_t'($urandom_range(0, 3));
            last = (close && i == count - 1) || (stray && $urandom_range(0, 199) == 0);
            send_sample(shaped_sample(pos, cl, shape), last);
        end
    endtask

    task automatic set_pace(input int unsigned phase);
        case (phase % 4)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 73; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 73; end
            default: begin idle_pct = 20; stall_pct = 20; end
        endcase
    endtask

    task automatic random_phase();
        int unsigned cl;
        int unsigned dl;
        int unsigned rl;
        int unsigned mr;
        int unsigned span;
        int unsigned rows;
        int unsigned count;
        cl = $urandom_range(0, 6);
        dl = $urandom_range(0, 6);
        rl = $urandom_range(0, 16);
        mr = ($urandom_range(0, 5) == 0) ? $urandom_range(33, 63) : $urandom_range(0, 8);
        configure(cl, dl, rl, mr);
        span = rl > cl + dl ? rl : cl + dl;
        if (span == 0)
            span = 1;
        repeat ($urandom_range(1, 4)) begin
            rows  = $urandom_range(0, (mr > MAX_ROWS ? MAX_ROWS : mr) + 2);
            count = rows * span;
            if ($urandom_range(0, 1) == 1)
                count += $urandom_range(0, span - 1);
            if (count == 0)
                count = 1;
            send_stream(count, span, cl, 1'b1, 1'b1);
        end
        if ($urandom_range(0, 3) == 0) begin
            count = $urandom_range(1, span);
            send_stream(count, span, cl, 1'b0, 1'b0);
        end
        settle();
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        send_sample(SMP_W'(0), 1'b1);
        settle();

        configure(2, 2, 3, 2);
        send_sample(SMP_W'(65535), 1'b0);
        send_sample(SMP_W'(0), 1'b0);
        send_sample(MIDSCALE, 1'b0);
        send_sample(MIDSCALE, 1'b0);
        send_sample(MIDSCALE, 1'b0);
        send_sample(SMP_W'(32767), 1'b0);
        send_sample(SMP_W'(1), 1'b0);
        send_sample(SMP_W'(65535), 1'b0);
        send_stream(4, 4, 2, 1'b1, 1'b0);
        send_sample(SMP_W'(65535), 1'b0);
        send_sample(SMP_W'(0), 1'b1);
        settle();

        configure(3, 2, 5, 1);
        send_sample(MIDSCALE, 1'b0);
        send_sample(MIDSCALE, 1'b0);
        send_sample(MIDSCALE, 1'b0);
        send_sample(SMP_W'(0), 1'b0);
        send_sample(SMP_W'(65535), 1'b1);
        settle();

        configure(0, 0, 0, 12'hFFF);
        send_stream(3, 1, 0, 1'b1, 1'b0);
        settle();

        configure(1, 1, 8, 4);
        send_stream(3, 8, 1, 1'b0, 1'b0);
        settle();
        write_reg(REG_ROW_LEN, CFG_DATA_W'(2));
        write_reg(REG_UNUSED_LO, 12'hFFF);
        write_reg(REG_UNUSED_HI, 12'hFFF);
        send_sample(SMP_W'(12345), 1'b1);
        settle();

        while (tally.samples_seen < ITEM_GOAL || phase_no < 4) begin
            set_pace(phase_no);
            if (phase_no == 1) begin
                configure(12'hFFF, 1, 1, 12'hFFF);
                send_stream(MAX_WINDOW + 4, MAX_WINDOW + 1, MAX_WINDOW, 1'b1, 1'b0);
                settle();
            end else begin
                random_phase();
            end
            phase_no++;
        end

        $display("%0d samples over %0d phases, %0d frame results checked, %0d mismatches",
                 tally.samples_seen, phase_no, tally.results_seen, tally.mismatches);
        $display("windows from empty to a saturated 1024-sample chirp, row limits 0 to saturated");
        if (tally.mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

[files.f]
sv/cwev_pkg.sv
sv/cwev_front.sv
sv/cwev_fifo.sv
sv/cwev_back.sv
sv/chirp_window_energy_vote_top.sv
tb/sv/chirp_window_energy_vote_top_test.sv
